@@ hdl/sqe_pkg.sv @@
// Package: shared types, constants and the arctangent table for the sprite quad expander.
package sqe_pkg;

  localparam int CORD_STEPS = 16;
  localparam logic signed [15:0] ANG_FULL    = 16'sd23040;
  localparam logic signed [15:0] ANG_HALF    = 16'sd11520;
  localparam logic signed [15:0] ANG_QUARTER = 16'sd5760;
  localparam logic signed [27:0] CORD_GAIN   = 28'sd10188014;

  // CORDIC datapath: x and y in Q24 (28 bits signed), angle in 2^-14 degree.
  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [23:0] z;
    logic               flip;
  } cord_t;

  // Sprite fields carried alongside the angle work.
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [24:0] lx0;
    logic signed [24:0] lx1;
    logic signed [24:0] ly0;
    logic signed [24:0] ly1;
    logic        [17:0] u0;
    logic        [17:0] v0;
    logic        [17:0] u1;
    logic        [17:0] v1;
    logic        [31:0] tint;
    logic               axis;
  } spr_t;

  function automatic logic signed [23:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:    atan_lut = 24'sd737280;
      4'd1:    atan_lut = 24'sd435242;
      4'd2:    atan_lut = 24'sd229970;
      4'd3:    atan_lut = 24'sd116736;
      4'd4:    atan_lut = 24'sd58595;
      4'd5:    atan_lut = 24'sd29326;
      4'd6:    atan_lut = 24'sd14667;
      4'd7:    atan_lut = 24'sd7334;
      4'd8:    atan_lut = 24'sd3667;
      4'd9:    atan_lut = 24'sd1833;
      4'd10:   atan_lut = 24'sd917;
      4'd11:   atan_lut = 24'sd458;
      4'd12:   atan_lut = 24'sd229;
      4'd13:   atan_lut = 24'sd115;
      4'd14:   atan_lut = 24'sd57;
      default: atan_lut = 24'sd29;
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) sat24 = 24'sd8388607;
    else if (v < -28'sd8388608) sat24 = -24'sd8388608;
    else sat24 = v[23:0];
  endfunction

endpackage

@@ hdl/sqe_cordic_stage.sv @@
// One registered CORDIC micro-rotation with a fixed shift.
module sqe_cordic_stage import sqe_pkg::*; #(
  parameter int Step = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  cord_t in_c,
  input  spr_t  in_s,
  output logic  out_vld,
  output cord_t out_c,
  output spr_t  out_s
);
  logic  vld_r;
  cord_t c_r, c_nxt;
  spr_t  s_r;

  always_comb begin
    c_nxt = in_c;
    if (in_c.z >= 0) begin
      c_nxt.x = in_c.x - (in_c.y >>> Step);
      c_nxt.y = in_c.y + (in_c.x >>> Step);
      c_nxt.z = in_c.z - atan_lut(4'(Step));
    end else begin
      c_nxt.x = in_c.x + (in_c.y >>> Step);
      c_nxt.y = in_c.y - (in_c.x >>> Step);
      c_nxt.z = in_c.z + atan_lut(4'(Step));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    c_r <= c_nxt;
    s_r <= in_s;
  end

  assign out_vld = vld_r;
  assign out_c   = c_r;
  assign out_s   = s_r;
endmodule

@@ hdl/sqe_front.sv @@
// Input stage: angle reduction, fold, local corner offsets.
module sqe_front import sqe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_width,
  input  logic signed [23:0] in_height,
  input  logic signed [23:0] in_pivot_x,
  input  logic signed [23:0] in_pivot_y,
  input  logic signed [15:0] in_angle,
  input  logic signed [17:0] in_tex_u0,
  input  logic signed [17:0] in_tex_v0,
  input  logic signed [17:0] in_tex_u1,
  input  logic signed [17:0] in_tex_v1,
  input  logic        [31:0] in_tint,
  output logic               out_vld,
  output cord_t              out_c,
  output spr_t               out_s
);
  logic signed [16:0] r1, r2, a;
  logic               flip;
  logic  vld_r;
  cord_t c_r, c_nxt;
  spr_t  s_r, s_nxt;

  always_comb begin
    // angle in [-32768, 32767]: at most two corrections up and one down by 23040.
    r1 = 17'(in_angle);
    if (r1 < 0) r1 = r1 + 17'(ANG_FULL);
    if (r1 < 0) r1 = r1 + 17'(ANG_FULL);
    r2 = r1;
    if (r2 >= 17'(ANG_FULL)) r2 = r2 - 17'(ANG_FULL);
    a = r2;
    if (a >= 17'(ANG_HALF)) a = a - 17'(ANG_FULL);
    flip = 1'b0;
    if (a > 17'(ANG_QUARTER)) begin
      a = a - 17'(ANG_HALF);
      flip = 1'b1;
    end else if (a < -17'(ANG_QUARTER)) begin
      a = a + 17'(ANG_HALF);
      flip = 1'b1;
    end
    c_nxt.x    = CORD_GAIN;
    c_nxt.y    = '0;
    c_nxt.z    = {a[15:0], 8'd0};
    c_nxt.flip = flip;
    s_nxt.pos_x = in_pos_x;
    s_nxt.pos_y = in_pos_y;
    s_nxt.lx0   = -25'(in_pivot_x);
    s_nxt.ly0   = -25'(in_pivot_y);
    s_nxt.lx1   = 25'(in_width) - 25'(in_pivot_x);
    s_nxt.ly1   = 25'(in_height) - 25'(in_pivot_y);
    s_nxt.u0    = in_tex_u0;
    s_nxt.v0    = in_tex_v0;
    s_nxt.u1    = in_tex_u1;
    s_nxt.v1    = in_tex_v1;
    s_nxt.tint  = in_tint;
    s_nxt.axis  = (r2 == 17'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    c_r <= c_nxt;
    s_r <= s_nxt;
  end

  assign out_vld = vld_r;
  assign out_c   = c_r;
  assign out_s   = s_r;
endmodule

@@ hdl/sqe_emit.sv @@
// Corner sequencer: multiplies, rounds, saturates and emits four vertices.
module sqe_emit import sqe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cord_t              in_c,
  input  spr_t               in_s,
  output logic               out_strobe,
  output logic        [1:0]  out_corner,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_y,
  output logic signed [17:0] out_vert_u,
  output logic signed [17:0] out_vert_v,
  output logic        [31:0] out_vert_color,
  output logic               out_last_corner
);
  logic signed [27:0] cx, cy;
  logic signed [16:0] cos_q, sin_q;
  logic signed [15:0] cos_nxt, sin_nxt;
  // Hold stage: the sprite and its sine/cosine, held for four corners.
  logic               hold_r;
  logic [1:0]         k_r;
  spr_t               s_r;
  logic signed [15:0] cos_r, sin_r;
  // Product stage.
  logic               p_vld_r;
  logic [1:0]         p_k_r;
  logic signed [41:0] xc_r, ys_r, xs_r, yc_r;
  logic signed [24:0] lx, ly;
  logic signed [23:0] p_px_r, p_py_r;
  logic [17:0]        p_u_r, p_v_r;
  logic [31:0]        p_tint_r;
  logic               p_axis_r;
  logic signed [24:0] p_lx_r, p_ly_r;
  logic signed [42:0] sx, sy;
  logic signed [27:0] rx, ry;

  function automatic logic signed [15:0] q15(input logic signed [27:0] v);
    logic signed [28:0] t;
    logic signed [19:0] q;
    t = 29'(v) + 29'sd256;
    q = 20'(t >>> 9);
    if (q > 20'sd32767) q15 = 16'sd32767;
    else if (q < -20'sd32768) q15 = -16'sd32768;
    else q15 = q[15:0];
  endfunction

  always_comb begin
    cx = in_c.flip ? -in_c.x : in_c.x;
    cy = in_c.flip ? -in_c.y : in_c.y;
    cos_nxt = q15(cx);
    sin_nxt = q15(cy);
    cos_q = 17'(cos_r);
    sin_q = 17'(sin_r);
    lx = (k_r[1]) ? s_r.lx1 : s_r.lx0;
    ly = (k_r == 2'd1 || k_r == 2'd2) ? s_r.ly1 : s_r.ly0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      k_r    <= '0;
    end else if (in_vld) begin
      hold_r <= 1'b1;
      k_r    <= '0;
    end else if (hold_r) begin
      k_r <= k_r + 2'd1;
      if (k_r == 2'd3) hold_r <= 1'b0;
    end
    if (in_vld) begin
      s_r   <= in_s;
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else p_vld_r <= hold_r;
    p_k_r    <= k_r;
    xc_r     <= 42'(lx * cos_q);
    ys_r     <= 42'(ly * sin_q);
    xs_r     <= 42'(lx * sin_q);
    yc_r     <= 42'(ly * cos_q);
    p_lx_r   <= lx;
    p_ly_r   <= ly;
    p_px_r   <= s_r.pos_x;
    p_py_r   <= s_r.pos_y;
    p_u_r    <= (k_r[1]) ? s_r.u1 : s_r.u0;
    p_v_r    <= (k_r == 2'd1 || k_r == 2'd2) ? s_r.v1 : s_r.v0;
    p_tint_r <= s_r.tint;
    p_axis_r <= s_r.axis;
  end

  always_comb begin
    sx = 43'(xc_r) - 43'(ys_r) + 43'sd16384;
    sy = 43'(xs_r) + 43'(yc_r) + 43'sd16384;
    if (p_axis_r) begin
      rx = 28'(p_lx_r) + 28'(p_px_r);
      ry = 28'(p_ly_r) + 28'(p_py_r);
    end else begin
      rx = 28'(sx >>> 15) + 28'(p_px_r);
      ry = 28'(sy >>> 15) + 28'(p_py_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= p_vld_r;
    out_corner      <= p_k_r;
    out_vert_x      <= sat24(rx);
    out_vert_y      <= sat24(ry);
    out_vert_u      <= p_u_r;
    out_vert_v      <= p_v_r;
    out_vert_color  <= p_tint_r;
    out_last_corner <= (p_k_r == 2'd3);
  end
endmodule

@@ hdl/sprite_quad_expander.sv @@
// Sprite quad expander: one sprite in, four corner vertices out, one per cycle.
// out_strobe for the first vertex follows the front stage, the CORDIC stages and
// the hold, product and output registers; the others follow back to back. Sprites
// overlap in the pipeline, but busy is high after each accepted start so that the
// single corner multiplier stage, one vertex a cycle, is not overrun. Reset (rst_n
// low, synchronous) clears all valid bits; the receiver cannot stall results.
module sprite_quad_expander import sqe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_width,
  input  logic signed [23:0] in_height,
  input  logic signed [23:0] in_pivot_x,
  input  logic signed [23:0] in_pivot_y,
  input  logic signed [15:0] in_angle,
  input  logic signed [17:0] in_tex_u0,
  input  logic signed [17:0] in_tex_v0,
  input  logic signed [17:0] in_tex_u1,
  input  logic signed [17:0] in_tex_v1,
  input  logic        [31:0] in_tint,
  output logic               out_strobe,
  output logic        [1:0]  out_corner,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_y,
  output logic signed [17:0] out_vert_u,
  output logic signed [17:0] out_vert_v,
  output logic        [31:0] out_vert_color,
  output logic               out_last_corner
);
  // Rate limiter: a sprite occupies the corner sequencer for its four corners, and
  // since the pipeline ahead of it is a fixed-length shift line, holding off starts
  // while busy keeps the sequencer from ever being overrun.
  logic [1:0] gap_r;
  logic       take;

  assign busy = (gap_r != 2'd0);
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= '0;
    else if (take) gap_r <= 2'd3;
    else if (busy) gap_r <= gap_r - 2'd1;
  end

  logic  vld [CORD_STEPS+1];
  cord_t cc  [CORD_STEPS+1];
  spr_t  ss  [CORD_STEPS+1];

  // Stage one: angle reduction and local corners.
  sqe_front u_front (
    .clk, .rst_n, .in_vld(take),
    .in_pos_x, .in_pos_y, .in_width, .in_height, .in_pivot_x, .in_pivot_y,
    .in_angle, .in_tex_u0, .in_tex_v0, .in_tex_u1, .in_tex_v1, .in_tint,
    .out_vld(vld[0]), .out_c(cc[0]), .out_s(ss[0])
  );

  // Sixteen CORDIC micro-rotations, one register stage each.
  for (genvar g = 0; g < CORD_STEPS; g++) begin : g_cord
    sqe_cordic_stage #(.Step(g)) u_stage (
      .clk, .rst_n, .in_vld(vld[g]), .in_c(cc[g]), .in_s(ss[g]),
      .out_vld(vld[g+1]), .out_c(cc[g+1]), .out_s(ss[g+1])
    );
  end

  // Corner sequencer, multiply, round and saturate.
  sqe_emit u_emit (
    .clk, .rst_n, .in_vld(vld[CORD_STEPS]), .in_c(cc[CORD_STEPS]), .in_s(ss[CORD_STEPS]),
    .out_strobe, .out_corner, .out_vert_x, .out_vert_y, .out_vert_u, .out_vert_v,
    .out_vert_color, .out_last_corner
  );
endmodule
